// ===== rtl/core/ssd_pkg.sv =====
// Shared types, constants and the segment encoder for the seven-segment scan driver.
// No dependencies.
package ssd_pkg;

  localparam int unsigned NumDigits  = 4;
  localparam int unsigned RestW      = 14;
  localparam logic [15:0] ValueMax   = 16'd9999;
  localparam logic [7:0]  BlinkReloadRst = 8'd30;
  localparam logic [7:0]  SegDotBit  = 8'h40;

  localparam logic        ActLoad    = 1'b0;
  localparam logic        ActTick    = 1'b1;

  typedef logic [3:0] bcd_t;

  typedef struct packed {
    logic                       done;
    bcd_t [NumDigits-1:0]       digits;
  } conv_res_t;

  function automatic logic [7:0] seg_encode(input bcd_t d);
    logic [7:0] s;
    case (d)
      4'd0:    s = 8'hBE;
      4'd1:    s = 8'h82;
      4'd2:    s = 8'h3B;
      4'd3:    s = 8'hAB;
      4'd4:    s = 8'h87;
      4'd5:    s = 8'hAD;
      4'd6:    s = 8'hBD;
      4'd7:    s = 8'h8A;
      4'd8:    s = 8'hBF;
      default: s = 8'hAF;
    endcase
    return s;
  endfunction

endpackage

// ===== rtl/core/ssd_bcd_conv.sv =====
// Iterative binary to four-digit decimal converter: one shared subtract/compare per cycle.
// Depends on ssd_pkg.
module ssd_bcd_conv import ssd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [15:0]       value_i,
  output conv_res_t         res_o
);

  localparam logic StIdle = 1'b0;
  localparam logic StRun  = 1'b1;

  logic             state_q, state_d;
  logic [RestW-1:0] rest_q, rest_d;
  logic [1:0]       wsel_q, wsel_d;
  bcd_t             cnt_q, cnt_d;
  bcd_t [NumDigits-1:0] dig_q, dig_d;
  logic             done_q, done_d;

  logic [RestW-1:0] weight;
  logic [RestW:0]   diff;
  logic [15:0]      sat;

  always_comb begin
    unique case (wsel_q)
      2'd0:    weight = RestW'(1000);
      2'd1:    weight = RestW'(100);
      default: weight = RestW'(10);
    endcase
  end

  assign diff = {1'b0, rest_q} - {1'b0, weight};
  assign sat  = (value_i > ValueMax) ? ValueMax : value_i;

  always_comb begin
    state_d = state_q;
    rest_d  = rest_q;
    wsel_d  = wsel_q;
    cnt_d   = cnt_q;
    dig_d   = dig_q;
    done_d  = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          rest_d  = sat[RestW-1:0];
          wsel_d  = 2'd0;
          cnt_d   = '0;
          state_d = StRun;
        end
      end
      default: begin
        if (!diff[RestW] && cnt_q != 4'd9) begin
          rest_d = diff[RestW-1:0];
          cnt_d  = cnt_q + 4'd1;
        end else begin
          dig_d[2'd3 - wsel_q] = cnt_q;
          cnt_d = '0;
          if (wsel_q == 2'd2) begin
            dig_d[0] = (rest_q < RestW'(10)) ? rest_q[3:0] : 4'd9;
            done_d   = 1'b1;
            state_d  = StIdle;
          end else begin
            wsel_d = wsel_q + 2'd1;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      done_q  <= 1'b0;
      wsel_q  <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      wsel_q  <= wsel_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rest_q <= rest_d;
    dig_q  <= dig_d;
  end

  assign res_o.done   = done_q;
  assign res_o.digits = dig_q;

endmodule

// ===== rtl/core/seven_segment_scan_driver_top.sv =====
// Seven-segment scan driver top level: input/config handshakes, digit store, scan and blink.
// Depends on ssd_pkg and ssd_bcd_conv.
// Scan tick: result registered on the next edge; one tick per cycle while the output is not stalled and no load runs.
// Load: the value is converted by repeated subtraction in the single shared subtract/compare
// unit of the decimal converter; no input is taken meanwhile.
// Reset (rst_ni low, asynchronous): patterns, scan, blink state, selects clear; reload is 30.
module seven_segment_scan_driver_top import ssd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        action_i,
  input  logic [15:0] value_i,
  input  logic [2:0]  dot_digit_i,
  input  logic [2:0]  blink_digit_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  digit_index_o,
  output logic [7:0]  segment_byte_o,
  output logic        digit_on_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i
);

  localparam logic StIdle = 1'b0;
  localparam logic StLoad = 1'b1;

  logic                       state_q;
  logic [NumDigits-1:0][7:0]  pat_q;
  logic [1:0]                 scan_q;
  logic [7:0]                 bcnt_q;
  logic                       bphase_q;
  logic [2:0]                 dot_q, blink_q;
  logic [7:0]                 reload_q;
  logic                       ovalid_q;
  logic [1:0]                 oidx_q;
  logic [7:0]                 oseg_q;
  logic                       oon_q;

  logic      in_xfer, load_xfer, tick_xfer;
  logic      conv_start;
  conv_res_t conv_res;

  logic [1:0] pos;
  logic       on_blink, is_dot;
  logic       bphase_n;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == StIdle) && (!ovalid_q || out_ready_i);
  assign in_xfer     = in_valid_i && in_ready_o;
  assign load_xfer   = in_xfer && (action_i == ActLoad);
  assign tick_xfer   = in_xfer && (action_i == ActTick);
  assign conv_start  = load_xfer;

  ssd_bcd_conv u_conv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (conv_start),
    .value_i (value_i),
    .res_o   (conv_res)
  );

  assign pos      = scan_q + 2'd1;
  assign on_blink = (blink_q != 3'd0) && ({1'b0, pos} + 3'd1 == blink_q);
  assign is_dot   = (dot_q == {1'b0, pos} + 3'd1);
  assign bphase_n = (on_blink && bcnt_q == 8'd0) ? ~bphase_q : bphase_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      pat_q    <= '0;
      scan_q   <= '0;
      bcnt_q   <= '0;
      bphase_q <= 1'b0;
      dot_q    <= '0;
      blink_q  <= '0;
      reload_q <= BlinkReloadRst;
      ovalid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        reload_q <= cfg_data_i;
      end
      if (tick_xfer) begin
        ovalid_q <= 1'b1;
      end else if (out_ready_i) begin
        ovalid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (load_xfer) begin
            dot_q   <= dot_digit_i;
            blink_q <= blink_digit_i;
            state_q <= StLoad;
          end
          if (tick_xfer) begin
            scan_q   <= pos;
            if (on_blink) begin
              bphase_q <= bphase_n;
              bcnt_q   <= (bcnt_q == 8'd0) ? reload_q : bcnt_q - 8'd1;
            end
          end
        end
        default: begin
          if (conv_res.done) begin
            for (int i = 0; i < NumDigits; i++) begin
              pat_q[i] <= seg_encode(conv_res.digits[i]);
            end
            state_q <= StIdle;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_xfer) begin
      oidx_q <= pos;
      oseg_q <= is_dot ? (pat_q[pos] | SegDotBit) : pat_q[pos];
      oon_q  <= !on_blink || bphase_n;
    end
  end

  assign out_valid_o    = ovalid_q;
  assign digit_index_o  = oidx_q;
  assign segment_byte_o = oseg_q;
  assign digit_on_o     = oon_q;

  a_no_accept_in_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StLoad) |-> !in_ready_o)
    else $error("input accepted during decimal conversion");

  a_done_only_in_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    conv_res.done |-> (state_q == StLoad))
    else $error("converter finished outside a load");

  a_tick_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_xfer |=> (out_valid_o && digit_index_o == $past(pos)))
    else $error("scan tick without its result");

  a_load_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_xfer && !(ovalid_q && !out_ready_i)) |=> !out_valid_o)
    else $error("load produced a result");

endmodule

// ===== test/seven_segment_scan_driver_top_tb.sv =====
// Testbench for seven_segment_scan_driver_top: directed and random loads and scan ticks
// go through a burst-mode driver, and a stalling monitor checks the results against a
// cycle-free predictor of the display. Depends on ssd_pkg and the RTL.
module seven_segment_scan_driver_top_tb import ssd_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] SegTable [10] = '{
    8'hBE, 8'h82, 8'h3B, 8'hAB, 8'h87, 8'hAD, 8'hBD, 8'h8A, 8'hBF, 8'hAF
  };
  localparam int LoadSettle = 40;
  localparam int LongHold   = 400;

  typedef struct packed {
    logic        act;
    logic [15:0] value;
    logic [2:0]  dot;
    logic [2:0]  blink;
  } disp_item_t;

  typedef struct packed {
    logic [1:0] idx;
    logic [7:0] seg;
    logic       on;
  } scan_res_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid = 1'b0;
  disp_item_t in_item = '0;
  logic       out_ready = 1'b0;
  logic       cfg_valid = 1'b0;
  logic [7:0] cfg_data = '0;

  logic       in_ready_o;
  logic       out_valid_o;
  logic [1:0] digit_index_o;
  logic [7:0] segment_byte_o;
  logic       digit_on_o;
  logic       cfg_ready_o;

  seven_segment_scan_driver_top DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready_o),
    .action_i       (in_item.act),
    .value_i        (in_item.value),
    .dot_digit_i    (in_item.dot),
    .blink_digit_i  (in_item.blink),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready),
    .digit_index_o  (digit_index_o),
    .segment_byte_o (segment_byte_o),
    .digit_on_o     (digit_on_o),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // display state as the block should hold it
  logic [7:0] pat_q [4];
  logic [1:0] scan_pos;
  logic [7:0] blink_cnt;
  logic       blink_on;
  logic [2:0] dot_sel;
  logic [2:0] blink_sel;
  logic [7:0] reload_val;

  disp_item_t pending_items [$];
  scan_res_t  expected_scans [$];
  int         errors = 0;
  int         n_results = 0;

  initial begin
    for (int i = 0; i < 4; i++) pat_q[i] = '0;
    scan_pos   = '0;
    blink_cnt  = '0;
    blink_on   = 1'b0;
    dot_sel    = '0;
    blink_sel  = '0;
    reload_val = BlinkReloadRst;
  end

  function automatic void predict_display(input disp_item_t it);
    logic [15:0] n;
    logic [7:0]  p;
    logic        on_blink;
    scan_res_t   r;
    if (it.act == ActLoad) begin
      n = (it.value > ValueMax) ? ValueMax : it.value;
      pat_q[3]  = SegTable[n / 1000];
      pat_q[2]  = SegTable[(n / 100) % 10];
      pat_q[1]  = SegTable[(n / 10) % 10];
      pat_q[0]  = SegTable[n % 10];
      dot_sel   = it.dot;
      blink_sel = it.blink;
    end else begin
      scan_pos = scan_pos + 2'd1;
      p = pat_q[scan_pos];
      on_blink = (blink_sel != 3'd0) && (blink_sel == 3'(scan_pos) + 3'd1);
      if (dot_sel == 3'(scan_pos) + 3'd1) p = p | SegDotBit;
      if (on_blink) begin
        if (blink_cnt == 8'd0) begin
          blink_on  = ~blink_on;
          blink_cnt = reload_val;
        end else begin
          blink_cnt = blink_cnt - 8'd1;
        end
      end
      r.idx = scan_pos;
      r.seg = p;
      r.on  = !on_blink || blink_on;
      expected_scans.push_back(r);
    end
  endfunction

  // sender: bursts of random length, random gaps
  int burst_left = 0;
  int idle_left = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready_o) predict_display(in_item);
      if (!in_valid || in_ready_o) begin
        if (idle_left > 0) begin
          idle_left--;
          in_valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          in_item  <= pending_items.pop_front();
          in_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            idle_left  = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall pattern re-picked at random from three modes, with two long hold-offs
  int        rx_tick = 0;
  int        rx_mode = 0;
  int        rx_hold_left = 0;
  scan_res_t want;
  scan_res_t got;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready) begin
        got = '{idx: digit_index_o, seg: segment_byte_o, on: digit_on_o};
        if (expected_scans.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result: idx %0d seg %02h on %0b", got.idx, got.seg, got.on);
        end else begin
          want = expected_scans.pop_front();
          if (got.idx !== want.idx || got.seg !== want.seg || got.on !== want.on) begin
            errors++;
            if (errors <= 10)
              $display("mismatch at result %0d: expected idx %0d seg %02h on %0b,",
                       n_results, want.idx, want.seg, want.on,
                       " got idx %0d seg %02h on %0b", got.idx, got.seg, got.on);
          end
        end
        n_results++;
        if (n_results == 150 || n_results == 1000) rx_hold_left = LongHold;
      end
      rx_tick++;
      if (rx_tick % 97 == 0) rx_mode = $urandom_range(0, 2);
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (rx_mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(0, 1));
          default: out_ready <= (rx_tick % 7) >= 3;
        endcase
      end
    end
  end

  function automatic disp_item_t make_item(logic act, logic [15:0] value, logic [2:0] dot,
                                           logic [2:0] blink);
    disp_item_t it;
    it.act   = act;
    it.value = value;
    it.dot   = dot;
    it.blink = blink;
    return it;
  endfunction

  // scan tick with junk in the ignored fields
  function automatic disp_item_t rand_tick();
    return make_item(ActTick, 16'($urandom), 3'($urandom), 3'($urandom));
  endfunction

  function automatic disp_item_t rand_load();
    logic [15:0] v;
    case ($urandom_range(0, 5))
      0:       v = 16'($urandom_range(0, 9));
      1:       v = 16'($urandom_range(0, 9999));
      2:       v = 16'($urandom_range(10000, 65535));
      3:       v = ($urandom_range(0, 1) != 0) ? 16'd9999 : 16'd10000;
      4:       v = 16'hFFFF;
      default: v = 16'($urandom);
    endcase
    return make_item(ActLoad, v, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
  endfunction

  task automatic push_ticks(int n);
    for (int i = 0; i < n; i++) pending_items.push_back(rand_tick());
  endtask

  // well-formed load-then-scan sequences, plus some back-to-back loads
  task automatic queue_random(int n);
    int cnt;
    int run;
    cnt = 0;
    while (cnt < n) begin
      pending_items.push_back(rand_load());
      cnt++;
      if ($urandom_range(0, 9) == 0) begin
        pending_items.push_back(rand_load());
        cnt++;
      end
      run = $urandom_range(1, 40);
      push_ticks(run);
      cnt += run;
    end
  endtask

  // every transfer done, every result in, then let a pending load settle
  task automatic drain();
    do @(posedge clk_i);
    while (pending_items.size() != 0 || in_valid || expected_scans.size() != 0);
    repeat (LoadSettle) @(posedge clk_i);
  endtask

  task automatic write_reload(logic [7:0] v);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    reload_val = v;
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    write_reload(8'd0);
    push_ticks(1);
    pending_items.push_back(make_item(ActLoad, 16'd0, 3'd0, 3'd0));
    push_ticks(4);
    pending_items.push_back(make_item(ActLoad, 16'd9999, 3'd4, 3'd1));
    push_ticks(4);
    pending_items.push_back(make_item(ActLoad, 16'hFFFF, 3'd7, 3'd7));
    push_ticks(2);
    pending_items.push_back(make_item(ActLoad, 16'd10000, 3'd1, 3'd5));
    push_ticks(1);
    pending_items.push_back(make_item(ActLoad, 16'd1234, 3'd2, 3'd4));
    push_ticks(4);
    pending_items.push_back(make_item(ActLoad, 16'd9, 3'd3, 3'd3));
    push_ticks(2);
    drain();

    write_reload(8'd1);
    queue_random(335);
    drain();
    write_reload(8'd255);
    queue_random(335);
    drain();
    write_reload(8'($urandom_range(2, 254)));
    queue_random(335);
    drain();
    write_reload(8'd0);
    queue_random(335);
    drain();
    write_reload(BlinkReloadRst);
    queue_random(335);
    drain();

    if (errors == 0 && expected_scans.size() == 0) begin
      $display("seven_segment_scan_driver_top test passed");
    end else begin
      $display("seven_segment_scan_driver_top test failed");
    end
    $finish;
  end

  initial begin
    #4ms;
    $display("seven_segment_scan_driver_top test failed");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/ssd_pkg.sv
rtl/core/ssd_bcd_conv.sv
rtl/core/seven_segment_scan_driver_top.sv
test/seven_segment_scan_driver_top_tb.sv
